### rtl/rational_arithmetic_unit_defines.svh
// Assertion macros shared by the rational arithmetic unit RTL.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// Antecedent in one cycle implies the consequent in the next cycle.
`define RAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Antecedent implies the consequent in the same cycle.
`define RAU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/rau_pkg.sv
// Package with the types and constants of the rational arithmetic unit.
`default_nettype none
package rau_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int RES_NUM_W = 33;
  localparam int RES_DEN_W = 31;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // Multiplier operand pair selected for a product step.
  typedef enum logic [1:0] {
    MSEL_P0  = 2'd0,
    MSEL_P1  = 2'd1,
    MSEL_DEN = 2'd2
  } msel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_SUM,
    S_CHECK,
    S_GCD,
    S_DIVN,
    S_DIVD
  } state_t;

  typedef struct packed {
    logic  load;
    logic  mul_en;
    msel_t mul_sel;
    logic  sum_en;
    logic  gcd_init;
    logic  gcd_step;
    logic  div_load_num;
    logic  div_load_den;
    logic  div_step;
    logic  fin_ok;
    logic  fin_err;
    logic  fin_zero;
  } cmd_t;

  typedef struct packed {
    logic den_zero;
    logic num_zero;
    logic gcd_done;
  } status_t;

endpackage
`default_nettype wire

### rtl/rau_datapath.sv
// Datapath: operand registers, shared multiplier, binary gcd and restoring divider.
`default_nettype none
`include "rational_arithmetic_unit_defines.svh"
module rau_datapath #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire rau_pkg::cmd_t                  cmd,
  output rau_pkg::status_t                    status,
  input  wire logic [1:0]                     in_opcode,
  input  wire logic [OPERAND_WIDTH-1:0]       in_num_first,
  input  wire logic [OPERAND_WIDTH-1:0]       in_den_first,
  input  wire logic [OPERAND_WIDTH-1:0]       in_num_second,
  input  wire logic [OPERAND_WIDTH-1:0]       in_den_second,
  output logic                                out_valid,
  output logic [rau_pkg::RES_NUM_W-1:0]       out_res_num,
  output logic [rau_pkg::RES_DEN_W-1:0]       out_res_den,
  output logic                                out_div_zero
);
  import rau_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int MW = W + 1;        // operand magnitude width
  localparam int PW = 2 * W + 1;    // product magnitude width
  localparam int NW = 2 * W + 2;    // numerator magnitude width
  localparam int KW = $clog2(NW + 1);

  // Operand registers as sign and magnitude.
  op_t           op_r;
  logic [MW-1:0] n1_r, d1_r, n2_r, d2_r;
  logic          n1s_r, d1s_r, n2s_r, d2s_r;

  logic [PW-1:0] p0_r, p1_r, pd_r;
  logic          p0s_r, p1s_r, pds_r;

  logic [NW-1:0] num_r;
  logic          nums_r;

  logic [NW-1:0] a_r, b_r, g_r, x_r, rem_r, qn_r;
  logic [KW-1:0] k_r;

  logic [RES_NUM_W-1:0] onum_r;
  logic [RES_DEN_W-1:0] oden_r;
  logic                 oerr_r, ovalid_r;

  // Magnitude of a two's complement operand.
  function automatic logic [MW-1:0] mag_of(input logic [W-1:0] v);
    logic [MW-1:0] e;
    e = {v[W-1], v};
    return v[W-1] ? (~e + MW'(1)) : e;
  endfunction

  // Operand load on an accepted beat.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_t'(in_opcode);
      n1_r  <= mag_of(in_num_first);
      d1_r  <= mag_of(in_den_first);
      n2_r  <= mag_of(in_num_second);
      d2_r  <= mag_of(in_den_second);
      n1s_r <= in_num_first[W-1];
      d1s_r <= in_den_first[W-1];
      n2s_r <= in_num_second[W-1];
      d2s_r <= in_den_second[W-1];
    end
  end

  // Multiplier operand selection.
  logic [MW-1:0] ma, mb;
  logic          sa, sb;
  always_comb begin
    ma = n1_r; mb = d2_r; sa = n1s_r; sb = d2s_r;
    case (cmd.mul_sel)
      MSEL_P0: begin
        if (op_r == OP_MUL) begin
          mb = n2_r; sb = n2s_r;
        end
      end
      MSEL_P1: begin
        ma = n2_r; mb = d1_r; sa = n2s_r; sb = d1s_r;
      end
      MSEL_DEN: begin
        if (op_r == OP_DIV) begin
          ma = d1_r; mb = n2_r; sa = d1s_r; sb = n2s_r;
        end else begin
          ma = d2_r; mb = d1_r; sa = d2s_r; sb = d1s_r;
        end
      end
      default: begin
        ma = n1_r; mb = d2_r; sa = n1s_r; sb = d2s_r;
      end
    endcase
  end

  logic [2*MW-1:0] prod;
  logic [PW-1:0]   prod_m;
  logic            prod_s;
  assign prod   = ma * mb;
  assign prod_m = prod[PW-1:0];
  assign prod_s = (prod_m != '0) && (sa ^ sb);

  // Product registers; the second product is negated for subtract and
  // unused for multiply and divide.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MSEL_P0: begin
          p0_r  <= prod_m;
          p0s_r <= prod_s;
        end
        MSEL_P1: begin
          if (op_r == OP_MUL || op_r == OP_DIV) begin
            p1_r  <= '0;
            p1s_r <= 1'b0;
          end else begin
            p1_r  <= prod_m;
            p1s_r <= (op_r == OP_SUB) ? ((prod_m != '0) && !prod_s) : prod_s;
          end
        end
        default: begin
          pd_r  <= prod_m;
          pds_r <= prod_s;
        end
      endcase
    end
  end

  // Signed sum of the two products.
  logic [NW:0] s0, s1, ssum, sabs;
  always_comb begin
    s0   = p0s_r ? -{2'b00, p0_r} : {2'b00, p0_r};
    s1   = p1s_r ? -{2'b00, p1_r} : {2'b00, p1_r};
    ssum = s0 + s1;
    sabs = ssum[NW] ? -ssum : ssum;
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      num_r  <= sabs[NW-1:0];
      nums_r <= ssum[NW];
    end
  end

  // Binary gcd step and the divisor it yields.
  logic [NW-1:0] gcd_g;
  assign gcd_g = a_r << k_r;

  always_ff @(posedge clk) begin
    if (cmd.gcd_init) begin
      a_r <= num_r;
      b_r <= {1'b0, pd_r};
      k_r <= '0;
    end else if (cmd.gcd_step) begin
      if (!a_r[0] && !b_r[0]) begin
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
        k_r <= k_r + KW'(1);
      end else if (!a_r[0]) begin
        a_r <= a_r >> 1;
      end else if (!b_r[0]) begin
        b_r <= b_r >> 1;
      end else if (a_r > b_r) begin
        a_r <= (a_r - b_r) >> 1;
      end else begin
        b_r <= (b_r - a_r) >> 1;
      end
    end
  end

  // Restoring divider, one quotient bit per cycle; the quotient
  // shifts into the dividend register.
  logic [NW:0] rem_sh;
  logic        qbit;
  assign rem_sh = {rem_r, x_r[NW-1]};
  assign qbit   = rem_sh >= {1'b0, g_r};

  always_ff @(posedge clk) begin
    if (cmd.div_load_num) begin
      g_r   <= gcd_g;
      x_r   <= num_r;
      rem_r <= '0;
    end else if (cmd.div_load_den) begin
      qn_r  <= x_r;
      x_r   <= {1'b0, pd_r};
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= qbit ? NW'(rem_sh - {1'b0, g_r}) : rem_sh[NW-1:0];
      x_r   <= {x_r[NW-2:0], qbit};
    end
  end

  // Result formatting and truncation to the port widths.
  logic [NW:0]           nsv;
  logic [NW+RES_NUM_W:0] nwide;
  logic [NW+RES_DEN_W-1:0] dwide;
  always_comb begin
    nsv   = (nums_r ^ pds_r) ? -{1'b0, qn_r} : {1'b0, qn_r};
    nwide = {{RES_NUM_W{nsv[NW]}}, nsv};
    dwide = {{RES_DEN_W{1'b0}}, x_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_ok) begin
      onum_r <= nwide[RES_NUM_W-1:0];
      oden_r <= dwide[RES_DEN_W-1:0];
      oerr_r <= 1'b0;
    end else if (cmd.fin_zero) begin
      onum_r <= '0;
      oden_r <= RES_DEN_W'(1);
      oerr_r <= 1'b0;
    end else if (cmd.fin_err) begin
      onum_r <= '0;
      oden_r <= '0;
      oerr_r <= 1'b1;
    end
  end

  // Result strobe, high for a single cycle for each result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= cmd.fin_ok | cmd.fin_zero | cmd.fin_err;
    end
  end

  assign status.den_zero = (pd_r == '0);
  assign status.num_zero = (num_r == '0);
  assign status.gcd_done = (a_r == b_r);

  assign out_valid    = ovalid_r;
  assign out_res_num  = onum_r;
  assign out_res_den  = oden_r;
  assign out_div_zero = oerr_r;

  `RAU_ASSERT_NEXT(a_err_zero, cmd.fin_err, ovalid_r && oerr_r && onum_r == '0 && oden_r == '0, "error beat must carry zero fields")
  `RAU_ASSERT_NOW(a_div_nonzero, cmd.div_step, g_r != '0, "divider runs with a zero divisor")

endmodule
`default_nettype wire

### rtl/rau_controller.sv
// Controller state machine sequencing products, gcd and divisions.
`default_nettype none
`include "rational_arithmetic_unit_defines.svh"
module rau_controller #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire rau_pkg::status_t status,
  output rau_pkg::cmd_t    cmd
);
  import rau_pkg::*;

  localparam int NW = 2 * OPERAND_WIDTH + 2;
  localparam int CW = $clog2(NW + 1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // State and bit counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    cmd.mul_sel = MSEL_P0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_P0;
        state_nxt   = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_P1;
        state_nxt   = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_DEN;
        state_nxt   = S_SUM;
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = S_CHECK;
      end
      S_CHECK: begin
        if (status.den_zero) begin
          cmd.fin_err = 1'b1;
          state_nxt   = S_IDLE;
        end else if (status.num_zero) begin
          cmd.fin_zero = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.gcd_init = 1'b1;
          state_nxt    = S_GCD;
        end
      end
      S_GCD: begin
        if (status.gcd_done) begin
          cmd.div_load_num = 1'b1;
          cnt_nxt          = '0;
          state_nxt        = S_DIVN;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIVN: begin
        if (cnt_r == CW'(NW)) begin
          cmd.div_load_den = 1'b1;
          cnt_nxt          = '0;
          state_nxt        = S_DIVD;
        end else begin
          cmd.div_step = 1'b1;
          cnt_nxt      = cnt_r + CW'(1);
        end
      end
      S_DIVD: begin
        if (cnt_r == CW'(NW)) begin
          cmd.fin_ok = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.div_step = 1'b1;
          cnt_nxt      = cnt_r + CW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  `RAU_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat must make the unit busy")
  `RAU_ASSERT_NEXT(a_finish_idle, cmd.fin_ok || cmd.fin_err || cmd.fin_zero, !busy, "unit must be idle after a result")

endmodule
`default_nettype wire

### rtl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit.
// Adds, subtracts, multiplies or divides two signed fractions and returns the
// result reduced by its gcd with a positive denominator; a zero denominator
// gives out_div_zero instead. A beat is taken when start is high and busy is
// low; the unit then stays busy for the whole item. An item that has a zero
// unreduced denominator or numerator ends at the check step. Otherwise it runs
// through the accept step, the shared multiplier steps S_MUL0, S_MUL1 and
// S_MUL2, the sum step, the check step, the binary gcd loop with its exit step
// and two bit-serial restoring divisions. The result appears for exactly one
// cycle with out_valid high; the receiver cannot stall it, so it must take
// every result.
`default_nettype none
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               in_opcode,
  input  wire logic [OPERAND_WIDTH-1:0] in_num_first,
  input  wire logic [OPERAND_WIDTH-1:0] in_den_first,
  input  wire logic [OPERAND_WIDTH-1:0] in_num_second,
  input  wire logic [OPERAND_WIDTH-1:0] in_den_second,
  output logic                          out_valid,
  output logic [rau_pkg::RES_NUM_W-1:0] out_res_num,
  output logic [rau_pkg::RES_DEN_W-1:0] out_res_den,
  output logic                          out_div_zero
);
  import rau_pkg::*;

  cmd_t    cmd;
  status_t status;

  rau_controller #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_opcode     (in_opcode),
    .in_num_first  (in_num_first),
    .in_den_first  (in_den_first),
    .in_num_second (in_num_second),
    .in_den_second (in_den_second),
    .out_valid     (out_valid),
    .out_res_num   (out_res_num),
    .out_res_den   (out_res_den),
    .out_div_zero  (out_div_zero)
  );

endmodule
`default_nettype wire

### bench/tb_rational_arithmetic_unit.sv
// Self-checking testbench for the rational arithmetic unit.
`timescale 1ns / 100ps
`default_nettype none
module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  localparam int W = OPERAND_WIDTH_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 250;

  // Expected result of one fraction operation.
  typedef struct {
    logic [RES_NUM_W-1:0] num;
    logic [RES_DEN_W-1:0] den;
    logic                 dz;
  } fraction_t;

  // Predicts reduced fractions and checks them in order.
  class fraction_scoreboard;
    fraction_t pending[$];
    int mismatches;
    int checked;

    function longint unsigned gcd64(longint unsigned a, longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      return a;
    endfunction

    // Works out the reduced result of one accepted beat.
    function void note_input(op_t op, logic signed [W-1:0] n1, logic signed [W-1:0] d1,
                             logic signed [W-1:0] n2, logic signed [W-1:0] d2);
      longint num, den, g, nm, dm;
      fraction_t f;
      case (op)
        OP_ADD: begin
          num = longint'(n1) * d2 + longint'(n2) * d1;
          den = longint'(d2) * d1;
        end
        OP_SUB: begin
          num = longint'(n1) * d2 - longint'(n2) * d1;
          den = longint'(d2) * d1;
        end
        OP_MUL: begin
          num = longint'(n1) * n2;
          den = longint'(d2) * d1;
        end
        default: begin
          num = longint'(n1) * d2;
          den = longint'(d1) * n2;
        end
      endcase
      if (den == 0) begin
        f.num = '0;
        f.den = '0;
        f.dz = 1'b1;
      end else begin
        nm = (num < 0) ? -num : num;
        dm = (den < 0) ? -den : den;
        g = gcd64(nm, dm);
        nm = nm / g;
        dm = dm / g;
        if ((num < 0) != (den < 0)) nm = -nm;
        f.num = nm[RES_NUM_W-1:0];
        f.den = dm[RES_DEN_W-1:0];
        f.dz = 1'b0;
      end
      pending.push_back(f);
    endfunction

    function void check_result(logic [RES_NUM_W-1:0] num, logic [RES_DEN_W-1:0] den,
                               logic dz);
      fraction_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %0d/%0d", num, den);
        return;
      end
      e = pending.pop_front();
      if (e.num !== num || e.den !== den || e.dz !== dz) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: expected %0d/%0d dz=%0b, got %0d/%0d dz=%0b",
                   $signed(e.num), e.den, e.dz, $signed(num), den, dz);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_opcode = '0;
  logic [W-1:0] in_num_first = '0, in_den_first = '0, in_num_second = '0, in_den_second = '0;
  logic out_valid;
  logic [RES_NUM_W-1:0] out_res_num;
  logic [RES_DEN_W-1:0] out_res_den;
  logic out_div_zero;

  fraction_scoreboard board = new();
  int idle_pct = 0;
  int beats = 0;
  int quiet_cycles = 0;

  rational_arithmetic_unit #(.OPERAND_WIDTH(W)) DUT (
    .clk, .rst_n, .start, .busy, .in_opcode, .in_num_first, .in_den_first,
    .in_num_second, .in_den_second, .out_valid, .out_res_num, .out_res_den, .out_div_zero
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      board.note_input(op_t'(in_opcode), in_num_first, in_den_first, in_num_second,
                       in_den_second);
      beats++;
    end
    if (rst_n && out_valid) board.check_result(out_res_num, out_res_den, out_div_zero);
  end

  // Watchdog on cycles with no accepted beat or result.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Holds one beat on the inputs until it is taken. The first falling edge
  // keeps the drive apart from the release of start by the previous beat.
  task automatic send(op_t op, logic [W-1:0] n1, logic [W-1:0] d1,
                      logic [W-1:0] n2, logic [W-1:0] d2);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    in_opcode <= op;
    in_num_first <= n1;
    in_den_first <= d1;
    in_num_second <= n2;
    in_den_second <= d2;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Operand picked from edge values, small values or full range.
  function automatic logic [W-1:0] pick_operand();
    logic [W-1:0] edges[6] = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 16'h0000, 16'h8001};
    case ($urandom_range(9))
      0: return edges[$urandom_range(5)];
      1, 2, 3, 4: return W'($signed($urandom_range(24)) - 12);
      default: return W'($urandom);
    endcase
  endfunction

  task automatic random_phase(int count, int pct);
    idle_pct = pct;
    repeat (count)
      send(op_t'($urandom_range(3)), pick_operand(), pick_operand(), pick_operand(),
           pick_operand());
  endtask

  initial begin
    op_t op;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed beats: every operation at the operand extremes, then zero cases.
    for (int k = 0; k < 4; k++) begin
      op = op_t'(k);
      send(op, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send(op, 16'h7FFF, 16'h8000, 16'h8001, 16'h7FFF);
      send(op, 16'd3, 16'hFFFA, 16'hFFFF, 16'd4);
    end
    send(OP_ADD, 16'd5, 16'd0, 16'd1, 16'd2);
    send(OP_MUL, 16'd5, 16'd3, 16'd1, 16'd0);
    send(OP_DIV, 16'd5, 16'd3, 16'd0, 16'd7);
    send(OP_MUL, 16'd0, 16'hFFFD, 16'd9, 16'd7);
    send(OP_SUB, 16'd2, 16'd3, 16'd4, 16'd6);
    send(OP_DIV, 16'h8000, 16'd1, 16'hFFFF, 16'd1);

    // Pause until every outstanding result is back.
    wait (board.pending.size() == 0);
    @(negedge clk);

    random_phase(225, 0);
    random_phase(225, 57);
    random_phase(225, 0);
    random_phase(225, 38);

    wait (board.pending.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d beats over all four operations, zero cases and idle phases.",
             beats);
    $display("Checked %0d results, %0d mismatches.", board.checked, board.mismatches);
    if (board.mismatches == 0 && board.pending.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
